// ===== rtl/core/b64lw_pkg.sv =====
`default_nettype none

package b64lw_pkg;

  localparam int JOB_BYTES = 6;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [9:0] MIN_LINE_LENGTH = 10'd4;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic REG_DIRECTION   = 1'b0;
  localparam logic REG_LINE_LENGTH = 1'b1;

  typedef logic [0:JOB_BYTES-1][7:0] job_bytes_t;

  // One queued job: the result bytes of one input group, in output order.
  typedef struct packed {
    job_bytes_t  bytes;
    logic [2:0]  count;
    logic        status;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'd65;
    end else if (v < 6'd52) begin
      return w + 8'd71;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

  function automatic logic [5:0] dec_value(input logic [7:0] ch);
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      return 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      return 6'(ch - 8'h47);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      return 6'(ch + 8'h04);
    end else if (ch == CHAR_PLUS) begin
      return 6'd62;
    end else if (ch == CHAR_SLASH) begin
      return 6'd63;
    end else begin
      return 6'd0;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64lw_front.sv =====
`default_nettype none

module b64lw_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [7:0]    data_value,
  input  wire logic          end_of_data,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_index,
  input  wire logic [9:0]    cfg_data,
  input  wire logic          queue_full,
  output b64lw_pkg::job_t    job,
  output logic               job_valid
);

  logic        direction;
  logic [9:0]  line_length;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_fill, group_fill_next;
  logic [9:0]  line_position, line_position_next;
  logic        pad_seen, pad_seen_next;
  logic [2:0]  pad_count, pad_count_next;

  logic              accept;
  logic [9:0]        len_eff;
  logic [23:0]       merged;
  logic [23:0]       enc_src;
  logic [2:0]        used;
  logic [0:3][7:0]   c;
  logic [10:0]       pos;
  logic [10:0]       rem_full;
  logic [2:0]        rem;
  logic [2:0]        split;
  logic              wrap;
  b64lw_pkg::job_bytes_t enc_bytes;
  logic              is_pad;
  logic              is_space;
  logic [2:0]        pads_new;
  logic [23:0]       dec_bits;
  logic [4:0]        dec_shift;

  assign accept = push && !queue_full;

  always_comb begin
    len_eff = line_length;
    if (line_length != 10'd0 && line_length < b64lw_pkg::MIN_LINE_LENGTH) begin
      len_eff = b64lw_pkg::MIN_LINE_LENGTH;
    end

    merged  = group_bits | ({data_value, 16'h0000} >> {group_fill, 3'b000});
    enc_src = end_of_data ? group_bits : merged;
    used    = end_of_data ? ({1'b0, group_fill} + 3'd1) : 3'd4;
    for (int k = 0; k < 4; k++) begin
      c[3 - k] = b64lw_pkg::enc_char(enc_src[6 * k +: 6]);
    end
    for (int k = 0; k < 4; k++) begin
      if (3'(k) >= used) begin
        c[k] = b64lw_pkg::CHAR_PAD;
      end
    end

    pos      = {1'b0, line_position} + 11'd4;
    wrap     = (len_eff != 10'd0) && (pos >= {1'b0, len_eff});
    rem_full = pos - {1'b0, len_eff};
    rem      = (rem_full > 11'd4) ? 3'd4 : rem_full[2:0];
    split    = 3'd4 - rem;

    if (!wrap) begin
      enc_bytes = '{c[0], c[1], c[2], c[3], 8'h00, 8'h00};
    end else begin
      unique case (split)
        3'd0:    enc_bytes = '{b64lw_pkg::CHAR_CR, b64lw_pkg::CHAR_LF, c[0], c[1], c[2], c[3]};
        3'd1:    enc_bytes = '{c[0], b64lw_pkg::CHAR_CR, b64lw_pkg::CHAR_LF, c[1], c[2], c[3]};
        3'd2:    enc_bytes = '{c[0], c[1], b64lw_pkg::CHAR_CR, b64lw_pkg::CHAR_LF, c[2], c[3]};
        3'd3:    enc_bytes = '{c[0], c[1], c[2], b64lw_pkg::CHAR_CR, b64lw_pkg::CHAR_LF, c[3]};
        default: enc_bytes = '{c[0], c[1], c[2], c[3], b64lw_pkg::CHAR_CR, b64lw_pkg::CHAR_LF};
      endcase
    end

    is_pad    = (data_value == b64lw_pkg::CHAR_PAD);
    is_space  = (data_value == b64lw_pkg::CHAR_SPACE) || (data_value == b64lw_pkg::CHAR_TAB) ||
                (data_value == b64lw_pkg::CHAR_LF) || (data_value == b64lw_pkg::CHAR_CR);
    pads_new  = pad_count + {2'b00, is_pad};
    dec_shift = 5'(group_fill) * 5'd6;
    dec_bits  = is_pad ? group_bits :
                (group_bits | ({b64lw_pkg::dec_value(data_value), 18'h00000} >> dec_shift));
  end

  always_comb begin
    group_bits_next    = group_bits;
    group_fill_next    = group_fill;
    line_position_next = line_position;
    pad_seen_next      = pad_seen;
    pad_count_next     = pad_count;
    job                = '0;
    job_valid          = 1'b0;

    if (accept) begin
      if (direction == b64lw_pkg::DIR_ENCODE) begin
        if (end_of_data || group_fill == 2'd2) begin
          if (!end_of_data || group_fill != 2'd0) begin
            job_valid = 1'b1;
            job.bytes = enc_bytes;
            job.count = wrap ? 3'd6 : 3'd4;
            if (len_eff != 10'd0) begin
              line_position_next = wrap ? {7'd0, rem} : pos[9:0];
            end
          end
          group_bits_next = '0;
          group_fill_next = '0;
          if (end_of_data) begin
            line_position_next = '0;
            pad_seen_next      = 1'b0;
            pad_count_next     = '0;
          end
        end else begin
          group_bits_next = merged;
          group_fill_next = group_fill + 2'd1;
        end
      end else begin
        if (end_of_data) begin
          if (group_fill != 2'd0) begin
            job_valid  = 1'b1;
            job.count  = 3'd1;
            job.status = 1'b1;
          end
          group_bits_next    = '0;
          group_fill_next    = '0;
          line_position_next = '0;
          pad_seen_next      = 1'b0;
          pad_count_next     = '0;
        end else if (!pad_seen && !is_space) begin
          if (group_fill != 2'd3) begin
            group_bits_next = dec_bits;
            group_fill_next = group_fill + 2'd1;
            pad_count_next  = pads_new;
          end else begin
            job.bytes = '{dec_bits[23:16], dec_bits[15:8], dec_bits[7:0], 8'h00, 8'h00, 8'h00};
            job.count = (pads_new >= 3'd3) ? 3'd0 : (3'd3 - pads_new);
            job_valid = (pads_new < 3'd3);
            if (pads_new != 3'd0) begin
              pad_seen_next = 1'b1;
            end
            group_bits_next = '0;
            group_fill_next = '0;
            pad_count_next  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= b64lw_pkg::DIR_ENCODE;
      line_length   <= '0;
      group_bits    <= '0;
      group_fill    <= '0;
      line_position <= '0;
      pad_seen      <= 1'b0;
      pad_count     <= '0;
    end else if (cfg_valid && cfg_index == b64lw_pkg::REG_DIRECTION) begin
      direction     <= cfg_data[0];
      group_bits    <= '0;
      group_fill    <= '0;
      line_position <= '0;
      pad_seen      <= 1'b0;
      pad_count     <= '0;
    end else begin
      if (cfg_valid && cfg_index == b64lw_pkg::REG_LINE_LENGTH) begin
        line_length <= cfg_data;
      end
      group_bits    <= group_bits_next;
      group_fill    <= group_fill_next;
      line_position <= line_position_next;
      pad_seen      <= pad_seen_next;
      pad_count     <= pad_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64lw_queue.sv =====
`default_nettype none

module b64lw_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire b64lw_pkg::job_t  wr_job,
  output logic                  full,
  input  wire logic             rd_en,
  output b64lw_pkg::job_t       rd_job,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64lw_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full   = (fill == CNT_W'(DEPTH));
  assign empty  = (fill == '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64lw_back.sv =====
`default_nettype none

module b64lw_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire b64lw_pkg::job_t  q_job,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire logic             pop,
  output logic                  empty,
  output logic [7:0]            out_value,
  output logic                  status,
  output logic                  last
);

  b64lw_pkg::job_t cur;
  logic            cur_valid;
  logic [2:0]      idx;
  logic            load;

  assign empty     = !cur_valid;
  assign out_value = cur.bytes[idx];
  assign status    = cur.status;
  assign last      = (idx == cur.count - 3'd1);
  assign load      = !cur_valid || (pop && last);
  assign q_pop     = load && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= !q_empty;
      idx       <= '0;
    end else if (pop) begin
      idx <= idx + 3'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/base64_codec_line_wrap_top.sv =====
// Path: the job of an accepted request is written into the job queue, then loaded into the
// output-stage register, from which the result ports are driven.
// Throughput: one request per cycle while the job queue has room, and one result per cycle
// from the output stage while jobs are queued; a wrapped encode group of three bytes gives six
// results, so the single result port, not the request side, sets the sustained rate.
// Reset: synchronous; clears registers, group state, the job queue and the output stage.
`default_nettype none

module base64_codec_line_wrap_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_value,
  input  wire logic        end_of_data,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_value,
  output logic             status,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data
);

  b64lw_pkg::job_t front_job;
  b64lw_pkg::job_t queue_job;
  logic            front_job_valid;
  logic            queue_full;
  logic            queue_empty;
  logic            queue_pop;

  assign cfg_ready = 1'b1;
  assign full      = queue_full;

  b64lw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .data_value  (data_value),
    .end_of_data (end_of_data),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .queue_full  (queue_full),
    .job         (front_job),
    .job_valid   (front_job_valid)
  );

  b64lw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_job_valid),
    .wr_job (front_job),
    .full   (queue_full),
    .rd_en  (queue_pop),
    .rd_job (queue_job),
    .empty  (queue_empty)
  );

  b64lw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_job     (queue_job),
    .q_empty   (queue_empty),
    .q_pop     (queue_pop),
    .pop       (pop),
    .empty     (empty),
    .out_value (out_value),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire
